// ===== hdl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and constants of the first-fit allocator
// Widths, opcodes, status codes and transaction structs.
// ----------------------------------------------------------------------------
package ffa_pkg;
	localparam int MAX_FREE_BLOCKS = 32;
	localparam int ADDR_BITS = 10;
	localparam int SIZE_BITS = ADDR_BITS + 1;
	localparam int IDX_BITS = $clog2(MAX_FREE_BLOCKS);
	localparam int CNT_BITS = $clog2(MAX_FREE_BLOCKS + 1);

	localparam logic [1:0] OP_INIT = 2'd0;
	localparam logic [1:0] OP_PROBE = 2'd1;
	localparam logic [1:0] OP_ALLOC = 2'd2;
	localparam logic [1:0] OP_FREE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [0:0] CFG_BASE = 1'd0;
	localparam logic [0:0] CFG_SIZE = 1'd1;

	localparam logic [ADDR_BITS-1:0] RESET_BASE = ADDR_BITS'(64);
	localparam logic [SIZE_BITS-1:0] RESET_SIZE = SIZE_BITS'(960);
	localparam logic [SIZE_BITS-1:0] ASPACE = SIZE_BITS'(1) << ADDR_BITS;

	typedef struct packed {
		logic [1:0] opcode;
		logic [10:0] blk_size;
		logic [9:0] block_start;
	} ffa_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [9:0] alloc_start;
	} ffa_rsp_t;

	// Row command sent to every cell, with its position, start and size operands.
	typedef enum logic [2:0] {
		CMD_HOLD, CMD_INIT, CMD_SHL, CMD_SHR, CMD_LOAD
	} ffa_cmd_t;

	typedef struct packed {
		ffa_cmd_t cmd;
		logic [IDX_BITS-1:0] pos;
		logic [ADDR_BITS-1:0] st;
		logic [SIZE_BITS-1:0] sz;
	} ffa_ctl_t;

	typedef struct packed {
		logic valid;
		logic [ADDR_BITS-1:0] st;
		logic [SIZE_BITS-1:0] sz;
	} ffa_ent_t;
endpackage

// ===== hdl/ffa_cell.sv =====
// ----------------------------------------------------------------------------
// ffa_cell: one entry of the free-block table
// Holds a start and size, shifts to or from its neighbors, loads on command.
// ----------------------------------------------------------------------------
module ffa_cell import ffa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [IDX_BITS-1:0] my_idx,
	input ffa_ctl_t ctl,
	input ffa_ent_t from_lo,
	input ffa_ent_t from_hi,
	input ffa_ent_t init_ent,
	output ffa_ent_t ent
);
	ffa_ent_t ent_q;
	assign ent = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= (my_idx == '0) ?
				ffa_ent_t'{valid: 1'b1, st: RESET_BASE, sz: RESET_SIZE} : ffa_ent_t'('0);
		end else begin
			unique case (ctl.cmd)
				CMD_INIT: ent_q <= init_ent;
				CMD_SHL: if (my_idx >= ctl.pos) ent_q <= from_hi;
				CMD_SHR: begin
					if (my_idx > ctl.pos) ent_q <= from_lo;
					else if (my_idx == ctl.pos)
						ent_q <= '{valid: 1'b1, st: ctl.st, sz: ctl.sz};
				end
				CMD_LOAD: if (my_idx == ctl.pos)
					ent_q <= '{valid: 1'b1, st: ctl.st, sz: ctl.sz};
				default: ;
			endcase
		end
	end
endmodule

// ===== hdl/ffa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffa_ctrl: command sequencer of the allocator
// Searches the table, decides the edit and issues one row command, two for a double merge.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ffa_req_t req,
	input logic [ADDR_BITS-1:0] base_q,
	input logic [SIZE_BITS-1:0] rsize_q,
	input ffa_ent_t ents [MAX_FREE_BLOCKS],
	output logic busy,
	output ffa_ctl_t ctl,
	output ffa_ent_t init_ent,
	output logic done,
	output ffa_rsp_t rsp
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EDIT = 2'd2;
	localparam logic [1:0] S_EDIT2 = 2'd3;

	logic [1:0] state_q, state_d;
	ffa_req_t req_q;
	logic [IDX_BITS-1:0] pos_q;
	logic fit_q, mnext_q, mprev_q, full_q;
	ffa_ent_t hit_q, prev_q;
	logic [SIZE_BITS-1:0] fsz_q;
	logic done_d;
	ffa_ctl_t ctl_d;
	ffa_rsp_t rsp_d;

	logic [MAX_FREE_BLOCKS-1:0] fit_v, below_v;
	logic [IDX_BITS-1:0] fit_idx, ins_idx, prv_idx;
	logic fit_any;
	logic [CNT_BITS-1:0] cnt, ins_pos;
	logic [SIZE_BITS-1:0] fsz, room, isz;
	logic [SIZE_BITS:0] nxt_end, prv_end;

	always_comb begin
		fit_idx = '0;
		fit_any = 1'b0;
		ins_pos = CNT_BITS'(MAX_FREE_BLOCKS);
		cnt = '0;
		for (int i = MAX_FREE_BLOCKS - 1; i >= 0; i--) begin
			fit_v[i] = ents[i].valid && ents[i].sz >= req_q.blk_size;
			below_v[i] = ents[i].valid && ents[i].st < req_q.block_start;
			if (fit_v[i]) begin
				fit_idx = IDX_BITS'(i);
				fit_any = 1'b1;
			end
			if (!below_v[i]) ins_pos = CNT_BITS'(i);
		end
		for (int i = 0; i < MAX_FREE_BLOCKS; i++) begin
			if (ents[i].valid) cnt = CNT_BITS'(i + 1);
		end
		ins_idx = ins_pos[IDX_BITS-1:0];
		prv_idx = ins_idx - 1'b1;
		room = ASPACE - {1'b0, req_q.block_start};
		fsz = (req_q.blk_size > room) ? room : req_q.blk_size;
		room = ASPACE - {1'b0, base_q};
		isz = (rsize_q > room) ? room : rsize_q;
		nxt_end = {2'b0, req_q.block_start} + {1'b0, fsz};
		prv_end = {2'b0, ents[prv_idx].st} + {1'b0, ents[prv_idx].sz};
		init_ent = '{valid: isz != '0, st: base_q, sz: isz};
	end

	assign busy = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		done_d = 1'b0;
		ctl_d = ctl;
		ctl_d.cmd = CMD_HOLD;
		rsp_d = rsp;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_SCAN;
			S_SCAN: state_d = S_EDIT;
			S_EDIT: begin
				rsp_d = '{status: ST_OK, alloc_start: '0};
				done_d = 1'b1;
				state_d = S_IDLE;
				unique case (req_q.opcode)
					OP_INIT: ctl_d.cmd = CMD_INIT;
					OP_PROBE: if (!fit_q) rsp_d.status = ST_NOFIT;
					OP_ALLOC: begin
						if (!fit_q) rsp_d.status = ST_NOFIT;
						else begin
							rsp_d.alloc_start = hit_q.st;
							ctl_d.pos = pos_q;
							if (hit_q.sz == req_q.blk_size) ctl_d.cmd = CMD_SHL;
							else begin
								ctl_d.cmd = CMD_LOAD;
								ctl_d.st = hit_q.st + req_q.blk_size[ADDR_BITS-1:0];
								ctl_d.sz = hit_q.sz - req_q.blk_size;
							end
						end
					end
					OP_FREE: begin
						if (req_q.blk_size == '0) ;
						else if (mnext_q && mprev_q) begin
							ctl_d.cmd = CMD_LOAD;
							ctl_d.pos = pos_q - 1'b1;
							ctl_d.st = prev_q.st;
							ctl_d.sz = prev_q.sz + fsz_q + ents[pos_q].sz;
							done_d = 1'b0;
							state_d = S_EDIT2;
						end else if (mprev_q) begin
							ctl_d.cmd = CMD_LOAD;
							ctl_d.pos = pos_q - 1'b1;
							ctl_d.st = prev_q.st;
							ctl_d.sz = prev_q.sz + fsz_q;
						end else if (mnext_q) begin
							ctl_d.cmd = CMD_LOAD;
							ctl_d.pos = pos_q;
							ctl_d.st = req_q.block_start;
							ctl_d.sz = ents[pos_q].sz + fsz_q;
						end else if (full_q) rsp_d.status = ST_FULL;
						else begin
							ctl_d.cmd = CMD_SHR;
							ctl_d.pos = pos_q;
							ctl_d.st = req_q.block_start;
							ctl_d.sz = fsz_q;
						end
					end
					default: ;
				endcase
			end
			S_EDIT2: begin
				ctl_d.cmd = CMD_SHL;
				ctl_d.pos = pos_q;
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
			ctl <= '{cmd: CMD_HOLD, default: '0};
			rsp <= '0;
		end else begin
			state_q <= state_d;
			done <= done_d;
			ctl <= ctl_d;
			rsp <= rsp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) req_q <= req;
		if (state_q == S_SCAN) begin
			pos_q <= (req_q.opcode == OP_FREE) ? ins_idx : fit_idx;
			fit_q <= fit_any && req_q.blk_size != '0;
			hit_q <= ents[fit_idx];
			full_q <= cnt == CNT_BITS'(MAX_FREE_BLOCKS);
			mnext_q <= (ins_pos < cnt) && nxt_end == {2'b0, ents[ins_idx].st};
			mprev_q <= ins_pos != '0 && prv_end == {2'b0, req_q.block_start};
			prev_q <= ents[prv_idx];
			fsz_q <= fsz;
		end
	end
endmodule

// ===== hdl/first_fit_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_allocator_top: first-fit free-list allocator with coalescing
// A row of table cells under a small sequencer.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake
// req      in         start && !busy
// rsp      out        done strobe, one cycle
// cfg      in         cfg_valid && cfg_ready
// An item passes through capture, parallel compare over the cells, one row
// edit, and a second edit on a free that merges both neighbors. Reset loads
// the region as one block. The receiver cannot stall.
// ----------------------------------------------------------------------------
module first_fit_allocator_top import ffa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input ffa_req_t req,
	output logic done,
	output ffa_rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [SIZE_BITS-1:0] cfg_data
);
	logic [ADDR_BITS-1:0] base_q;
	logic [SIZE_BITS-1:0] rsize_q;
	ffa_ent_t ents [MAX_FREE_BLOCKS];
	ffa_ctl_t ctl;
	ffa_ent_t init_ent;
	ffa_ent_t zero_ent;

	assign cfg_ready = 1'b1;
	assign zero_ent = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= RESET_BASE;
			rsize_q <= RESET_SIZE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BASE: base_q <= cfg_data[ADDR_BITS-1:0];
				CFG_SIZE: rsize_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ffa_ctrl u_ctrl (
		.clk, .arst_n, .start, .req, .base_q, .rsize_q, .ents,
		.busy, .ctl, .init_ent, .done, .rsp
	);

	for (genvar i = 0; i < MAX_FREE_BLOCKS; i++) begin : g_cell
		ffa_cell u_cell (
			.clk, .arst_n,
			.my_idx(IDX_BITS'(i)),
			.ctl,
			.from_lo((i == 0) ? zero_ent : ents[(i == 0) ? 0 : i - 1]),
			.from_hi((i == MAX_FREE_BLOCKS - 1) ? zero_ent
				: ents[(i == MAX_FREE_BLOCKS - 1) ? i : i + 1]),
			.init_ent((i == 0) ? init_ent : zero_ent),
			.ent(ents[i])
		);
	end
endmodule

// ===== verif/first_fit_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// first_fit_allocator_checker: response predictor and scoreboard
// Watches the request, config and response channels, keeps its own copy of
// the free list, and compares every response with the oldest prediction.
// ----------------------------------------------------------------------------
module first_fit_allocator_checker import ffa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input ffa_req_t req,
	input logic done,
	input ffa_rsp_t rsp,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [SIZE_BITS-1:0] cfg_data,
	output int fail_count,
	output int pending_count
);
	logic [ADDR_BITS-1:0] base_reg;
	logic [SIZE_BITS-1:0] size_reg;
	logic [ADDR_BITS-1:0] free_st [MAX_FREE_BLOCKS];
	logic [SIZE_BITS-1:0] free_sz [MAX_FREE_BLOCKS];
	int free_cnt;
	ffa_rsp_t expected_rsp_q[$];

	assign pending_count = expected_rsp_q.size();

	function automatic void load_region();
		int s;
		s = size_reg;
		if (s > (1 << ADDR_BITS) - int'(base_reg))
			s = (1 << ADDR_BITS) - int'(base_reg);
		for (int i = 0; i < MAX_FREE_BLOCKS; i++) begin
			free_st[i] = '0;
			free_sz[i] = '0;
		end
		free_cnt = (s == 0) ? 0 : 1;
		if (s != 0) begin
			free_st[0] = base_reg;
			free_sz[0] = SIZE_BITS'(s);
		end
	endfunction

	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < free_cnt; i++) begin
			free_st[i] = free_st[i+1];
			free_sz[i] = free_sz[i+1];
		end
		free_cnt--;
		free_st[free_cnt] = '0;
		free_sz[free_cnt] = '0;
	endfunction

	function automatic int find_fit(int sz);
		for (int i = 0; i < free_cnt; i++)
			if (int'(free_sz[i]) >= sz) return i;
		return free_cnt;
	endfunction

	function automatic logic [1:0] release_block(int st, int sz);
		int pos;
		bit mnext, mprev;
		pos = 0;
		if (sz == 0) return ST_OK;
		if (sz > (1 << ADDR_BITS) - st) sz = (1 << ADDR_BITS) - st;
		while (pos < free_cnt && int'(free_st[pos]) < st) pos++;
		mnext = pos < free_cnt && st + sz == int'(free_st[pos]);
		mprev = pos > 0 && int'(free_st[pos-1]) + int'(free_sz[pos-1]) == st;
		if (mnext && mprev) begin
			free_sz[pos-1] = free_sz[pos-1] + SIZE_BITS'(sz) + free_sz[pos];
			drop_entry(pos);
		end else if (mprev) begin
			free_sz[pos-1] = free_sz[pos-1] + SIZE_BITS'(sz);
		end else if (mnext) begin
			free_st[pos] = ADDR_BITS'(st);
			free_sz[pos] = free_sz[pos] + SIZE_BITS'(sz);
		end else begin
			if (free_cnt >= MAX_FREE_BLOCKS) return ST_FULL;
			for (int i = free_cnt; i > pos; i--) begin
				free_st[i] = free_st[i-1];
				free_sz[i] = free_sz[i-1];
			end
			free_st[pos] = ADDR_BITS'(st);
			free_sz[pos] = SIZE_BITS'(sz);
			free_cnt++;
		end
		return ST_OK;
	endfunction

	function automatic ffa_rsp_t predict_rsp(ffa_req_t r);
		ffa_rsp_t o;
		int sz, pos;
		o = '0;
		sz = r.blk_size;
		case (r.opcode)
			OP_INIT: load_region();
			OP_PROBE: if (sz == 0 || find_fit(sz) >= free_cnt) o.status = ST_NOFIT;
			OP_ALLOC: begin
				pos = (sz == 0) ? free_cnt : find_fit(sz);
				if (pos >= free_cnt) begin
					o.status = ST_NOFIT;
				end else begin
					o.alloc_start = free_st[pos];
					if (int'(free_sz[pos]) == sz) begin
						drop_entry(pos);
					end else begin
						free_st[pos] = free_st[pos] + ADDR_BITS'(sz);
						free_sz[pos] = free_sz[pos] - SIZE_BITS'(sz);
					end
				end
			end
			default: o.status = release_block(r.block_start, sz);
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ffa_rsp_t e;
		if (!arst_n) begin
			base_reg = RESET_BASE;
			size_reg = RESET_SIZE;
			load_region();
			expected_rsp_q.delete();
			fail_count = 0;
		end else begin
			if (done) begin
				if (expected_rsp_q.size() == 0) begin
					$error("response with no pending request");
					fail_count++;
				end else begin
					e = expected_rsp_q.pop_front();
					if (rsp.status !== e.status) begin
						$error("status expected %0d actual %0d", e.status, rsp.status);
						fail_count++;
					end
					if (rsp.alloc_start !== e.alloc_start) begin
						$error("alloc_start expected %0d actual %0d",
							e.alloc_start, rsp.alloc_start);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_BASE) base_reg = cfg_data[ADDR_BITS-1:0];
				else size_reg = cfg_data;
			end
			if (start && !busy) expected_rsp_q.push_back(predict_rsp(req));
		end
	end
endmodule

// ===== verif/first_fit_allocator_top_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_allocator_top_tb: stimulus and verdict for the allocator
// Directed corner requests, then random alloc/free/probe/init traffic in
// bursts over several region settings; the checker scores every response.
// ----------------------------------------------------------------------------
module first_fit_allocator_top_tb;
	import ffa_pkg::*;

	logic clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	ffa_req_t req;
	ffa_rsp_t rsp;
	logic [0:0] cfg_index;
	logic [SIZE_BITS-1:0] cfg_data;
	int fail_count, pending_count;
	int burst_left;
	logic [ADDR_BITS-1:0] live_st[$];
	logic [SIZE_BITS-1:0] live_sz[$];
	logic [SIZE_BITS-1:0] checker_last_size;
	logic [1:0] checker_last_op;

	first_fit_allocator_top dut (.*);
	first_fit_allocator_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic idle_gap();
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 12);
		end
	endtask

	task automatic send(logic [1:0] op, int sz, int st);
		idle_gap();
		req.opcode = op;
		req.blk_size = SIZE_BITS'(sz);
		req.block_start = ADDR_BITS'(st);
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic stop_requests();
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic write_reg(logic [0:0] idx, int value);
		stop_requests();
		while (pending_count != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_index <= idx;
		cfg_data <= SIZE_BITS'(value);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_item();
		int k, r, sz;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 40);
			send(OP_ALLOC, sz, $urandom_range(0, 1023));
		end else if (r < 85 && live_st.size() > 0) begin
			k = $urandom_range(0, live_st.size() - 1);
			send(OP_FREE, live_sz[k], live_st[k]);
			live_st.delete(k);
			live_sz.delete(k);
		end else if (r < 93) begin
			send(OP_PROBE, $urandom_range(0, 2047), $urandom_range(0, 1023));
		end else if (r < 98) begin
			send(OP_FREE, $urandom_range(0, 2047), $urandom_range(0, 1023));
		end else begin
			send(OP_INIT, $urandom_range(0, 2047), $urandom_range(0, 1023));
			live_st.delete();
			live_sz.delete();
		end
	endtask

	always @(posedge clk)
		if (done && checker_last_op == OP_ALLOC && rsp.status == ST_OK) begin
			live_st.push_back(rsp.alloc_start);
			live_sz.push_back(checker_last_size);
		end

	always @(posedge clk)
		if (start && !busy) begin
			checker_last_size <= req.blk_size;
			checker_last_op <= req.opcode;
		end

	initial begin
		int bases[4], sizes[4];
		bases = '{64, 0, 1023, 900};
		sizes = '{960, 1024, 2047, 0};
		arst_n = 0; start = 0; req = '0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
		burst_left = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send(OP_PROBE, 960, 0);
		send(OP_PROBE, 961, 0);
		send(OP_PROBE, 0, 0);
		send(OP_ALLOC, 0, 0);
		send(OP_ALLOC, 2047, 0);
		send(OP_ALLOC, 10, 0);
		send(OP_ALLOC, 20, 0);
		send(OP_FREE, 10, 64);
		send(OP_FREE, 20, 74);
		send(OP_FREE, 0, 5);
		send(OP_ALLOC, 960, 0);
		send(OP_FREE, 2047, 1023);
		send(OP_FREE, 4, 0);
		send(OP_FREE, 4, 8);
		send(OP_FREE, 4, 4);
		for (int i = 0; i < 33; i++) send(OP_FREE, 1, 20 + 2 * i);
		send(OP_FREE, 1, 21);
		send(OP_INIT, 0, 0);
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_BASE, bases[ph]);
			write_reg(CFG_SIZE, sizes[ph]);
			send(OP_INIT, 1, 0);
			live_st.delete();
			live_sz.delete();
			for (int n = 0; n < 400; n++) random_item();
		end
		stop_requests();
		while (pending_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
